### hw/rtl/map_point_view_projection_unit_assert.svh
// Assertion macros for the map point view projection unit.
// Used by the top level only; no other dependencies.
`ifndef MAP_POINT_VIEW_PROJECTION_UNIT_ASSERT_SVH
`define MAP_POINT_VIEW_PROJECTION_UNIT_ASSERT_SVH

// Combinational implication, checked every clock edge out of reset.
`define MPPV_ASSERT_IMPLY(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("implication check failed");

// Fixed-delay implication.
`define MPPV_ASSERT_DELAY(lbl, clk, rst, a, dly, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> ##dly (b)) \
      else $error("delayed check failed");

`endif

### hw/rtl/mppv_pkg.sv
// Package for the map point view projection unit: item types, codes, constants.
// No dependencies.
package mppv_pkg;

   localparam int CoordW  = 20;
   localparam int RotW    = 18;
   localparam int IndexW  = 16;
   localparam int PixW    = 16;
   localparam int ProdW   = RotW + CoordW;
   localparam int NumW    = 35;
   localparam int DenW    = 19;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 60;
   localparam int Latency = 3 + NumW + 1;

   localparam logic [1:0] STATUS_VISIBLE = 2'd0;
   localparam logic [1:0] STATUS_DEPTH   = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

   localparam logic [CsrIdxW-1:0] REG_ROT0   = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_ROT1   = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_ROT2   = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_TRANS  = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_FOCAL  = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_CENTER = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_DEPTH  = 3'd6;

   localparam logic [53:0] ROT0_RESET   = 54'd65536;
   localparam logic [53:0] ROT1_RESET   = 54'd17179869184;
   localparam logic [53:0] ROT2_RESET   = 54'd4503599627370496;
   localparam logic [59:0] TRANS_RESET  = 60'd0;
   localparam logic [31:0] FOCAL_RESET  = 32'd550510800;
   localparam logic [55:0] CENTER_RESET = 56'd8446998331528184;
   localparam logic [39:0] DEPTH_RESET  = 40'd34359739597;

   typedef struct packed {
      logic signed [CoordW-1:0] point_x;
      logic signed [CoordW-1:0] point_y;
      logic signed [CoordW-1:0] point_z;
      logic [IndexW-1:0]        map_point_index;
   } req_type;

   typedef struct packed {
      logic [1:0]        view_status;
      logic [PixW-1:0]   pixel_u;
      logic [PixW-1:0]   pixel_v;
      logic [IndexW-1:0] echoed_index;
   } rsp_type;

   typedef struct packed {
      logic                     valid;
      logic [IndexW-1:0]        index;
      logic signed [CoordW-1:0] xc;
      logic signed [CoordW-1:0] yc;
      logic signed [CoordW-1:0] zc;
   } xfm_type;

   typedef struct packed {
      logic              valid;
      logic              depth_ok;
      logic              sign_u;
      logic              sign_v;
      logic [IndexW-1:0] index;
   } tag_type;

endpackage

### hw/rtl/map_point_view_projection_unit.sv
// Top level of the map point view projection unit: config registers, depth test,
// pinhole projection and bounds check. Depends on mppv_pkg, mppv_transform, mppv_div.
//
//   channel  | ports                           | handshake
//   ---------+---------------------------------+------------------------------
//   input    | req_start, busy, req_item       | taken when req_start && !busy
//   result   | rsp_strobe, rsp_item            | one-cycle strobe, no backpressure
//   config   | csr_we, csr_index, csr_data     | written when csr_we is high
//
// One item enters per cycle; busy is never raised.
// The pipeline has two transform stages, one focal-product stage,
// a 35-stage divider (one quotient bit per stage) and an output register.
// Synchronous reset clears valid bits and loads the default calibration.
// The result side cannot stall, so the pipeline always advances.
module map_point_view_projection_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_start,
   output logic                            busy,
   input  mppv_pkg::req_type               req_item,
   output logic                            rsp_strobe,
   output mppv_pkg::rsp_type               rsp_item,
   input  logic                            csr_we,
   input  logic [mppv_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [mppv_pkg::CsrDataW-1:0]   csr_data
);
   import mppv_pkg::*;
   `include "map_point_view_projection_unit_assert.svh"

   logic [53:0] rot_ff [3];
   logic [59:0] trans_ff;
   logic [31:0] focal_ff;
   logic [55:0] center_ff;
   logic [39:0] depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= ROT0_RESET;
         rot_ff[1] <= ROT1_RESET;
         rot_ff[2] <= ROT2_RESET;
         trans_ff  <= TRANS_RESET;
         focal_ff  <= FOCAL_RESET;
         center_ff <= CENTER_RESET;
         depth_ff  <= DEPTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_ROT0:   rot_ff[0] <= csr_data[53:0];
            REG_ROT1:   rot_ff[1] <= csr_data[53:0];
            REG_ROT2:   rot_ff[2] <= csr_data[53:0];
            REG_TRANS:  trans_ff  <= csr_data[59:0];
            REG_FOCAL:  focal_ff  <= csr_data[31:0];
            REG_CENTER: center_ff <= csr_data[55:0];
            REG_DEPTH:  depth_ff  <= csr_data[39:0];
            default: ;
         endcase
      end
   end

   logic accept;
   assign busy   = 1'b0;
   assign accept = req_start && !busy;

   xfm_type xfm;

   mppv_transform u_xfm (
      .clock   (clock),
      .reset   (reset),
      .in_valid(accept),
      .in_item (req_item),
      .rot_row (rot_ff),
      .trans   (trans_ff),
      .out_xfm (xfm)
   );

   // focal product and depth test
   logic signed [36:0] prod_u, prod_v;
   logic [36:0]        mag_u, mag_v;
   logic               depth_ok;
   tag_type            tag_in, tag_ff;
   logic [NumW-1:0]    num_u_ff, num_v_ff;
   logic [DenW-1:0]    den_ff;

   always_comb begin
      prod_u   = $signed({1'b0, focal_ff[15:0]}) * xfm.xc;
      prod_v   = $signed({1'b0, focal_ff[31:16]}) * xfm.yc;
      mag_u    = prod_u[36] ? 37'(-prod_u) : 37'(prod_u);
      mag_v    = prod_v[36] ? 37'(-prod_v) : 37'(prod_v);
      depth_ok = ($signed({xfm.zc[CoordW-1], xfm.zc}) > $signed({1'b0, depth_ff[19:0]}))
              && ($signed({xfm.zc[CoordW-1], xfm.zc}) < $signed({1'b0, depth_ff[39:20]}));
      tag_in.valid    = xfm.valid;
      tag_in.depth_ok = depth_ok;
      tag_in.sign_u   = prod_u[36];
      tag_in.sign_v   = prod_v[36];
      tag_in.index    = xfm.index;
   end

   always_ff @(posedge clock) begin
      num_u_ff <= mag_u[NumW-1:0];
      num_v_ff <= mag_v[NumW-1:0];
      den_ff   <= depth_ok ? xfm.zc[DenW-1:0] : DenW'(1);
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   logic [NumW-1:0] quo_u, quo_v;
   tag_type         tag_d;
   logic            sign_v_d;

   mppv_div #(.NUM_W(NumW), .DEN_W(DenW), .TAG_W($bits(tag_type))) u_div_u (
      .clock  (clock),
      .reset  (reset),
      .num    (num_u_ff),
      .den    (den_ff),
      .tag    (tag_ff),
      .quo    (quo_u),
      .tag_out(tag_d)
   );

   mppv_div #(.NUM_W(NumW), .DEN_W(DenW), .TAG_W(1)) u_div_v (
      .clock  (clock),
      .reset  (reset),
      .num    (num_v_ff),
      .den    (den_ff),
      .tag    (tag_ff.sign_v),
      .quo    (quo_v),
      .tag_out(sign_v_d)
   );

   // offset by center and bounds check
   logic signed [37:0] u_pix, v_pix;
   logic [15:0]        w_lim, h_lim;
   logic               in_image;
   rsp_type            rsp_in, rsp_ff;
   logic               strobe_ff;

   always_comb begin
      u_pix = (tag_d.sign_u ? -$signed({3'b0, quo_u}) : $signed({3'b0, quo_u}))
            + $signed({22'b0, center_ff[15:0]});
      v_pix = (sign_v_d ? -$signed({3'b0, quo_v}) : $signed({3'b0, quo_v}))
            + $signed({22'b0, center_ff[31:16]});
      w_lim = {center_ff[43:32], 4'b0};
      h_lim = {center_ff[55:44], 4'b0};
      in_image = !u_pix[37] && !v_pix[37]
              && (u_pix < $signed({22'b0, w_lim})) && (v_pix < $signed({22'b0, h_lim}));
      rsp_in.echoed_index = tag_d.index;
      rsp_in.pixel_u      = '0;
      rsp_in.pixel_v      = '0;
      if (!tag_d.depth_ok) begin
         rsp_in.view_status = STATUS_DEPTH;
      end else if (in_image) begin
         rsp_in.view_status = STATUS_VISIBLE;
         rsp_in.pixel_u     = u_pix[PixW-1:0];
         rsp_in.pixel_v     = v_pix[PixW-1:0];
      end else begin
         rsp_in.view_status = STATUS_OUTSIDE;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= tag_d.valid;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   `MPPV_ASSERT_DELAY(a_item_latency, clock, reset, accept, Latency, rsp_strobe)
   `MPPV_ASSERT_IMPLY(a_hidden_zero_pixel, clock, reset,
      rsp_strobe && (rsp_item.view_status != STATUS_VISIBLE),
      (rsp_item.pixel_u == '0) && (rsp_item.pixel_v == '0))
   `MPPV_ASSERT_IMPLY(a_status_code, clock, reset, rsp_strobe,
      (rsp_item.view_status == STATUS_VISIBLE) || (rsp_item.view_status == STATUS_DEPTH)
      || (rsp_item.view_status == STATUS_OUTSIDE))

endmodule

### hw/rtl/mppv_transform.sv
// Two-stage rigid transform: products, then sum, floor and saturate to Q8.12.
// Depends on mppv_pkg.
module mppv_transform (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  mppv_pkg::req_type in_item,
   input  logic [53:0]       rot_row [3],
   input  logic [59:0]       trans,
   output mppv_pkg::xfm_type out_xfm
);
   import mppv_pkg::*;

   logic signed [ProdW-1:0]  prod_ff [3][3];
   logic signed [ProdW-1:0]  prod_in [3][3];
   logic                     s1_valid_ff;
   logic [IndexW-1:0]        s1_index_ff;
   logic signed [CoordW-1:0] pt [3];
   logic signed [40:0]       acc [3];
   logic signed [24:0]       shr [3];
   logic signed [CoordW-1:0] sat [3];
   logic signed [CoordW-1:0] tr [3];
   xfm_type                  xfm_ff, xfm_in;

   assign pt[0] = in_item.point_x;
   assign pt[1] = in_item.point_y;
   assign pt[2] = in_item.point_z;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = $signed(rot_row[r][RotW*c +: RotW]) * pt[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      s1_index_ff <= in_item.map_point_index;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         tr[r]  = $signed(trans[CoordW*r +: CoordW]);
         acc[r] = $signed({{5{tr[r][CoordW-1]}}, tr[r], 16'b0})
                + 41'(prod_ff[r][0]) + 41'(prod_ff[r][1]) + 41'(prod_ff[r][2]);
         shr[r] = acc[r][40:16];
         if (shr[r] > 25'sd524287) begin
            sat[r] = 20'sd524287;
         end else if (shr[r] < -25'sd524288) begin
            sat[r] = -20'sd524288;
         end else begin
            sat[r] = shr[r][CoordW-1:0];
         end
      end
      xfm_in.valid = s1_valid_ff;
      xfm_in.index = s1_index_ff;
      xfm_in.xc    = sat[0];
      xfm_in.yc    = sat[1];
      xfm_in.zc    = sat[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xfm_ff <= '0;
      end else begin
         xfm_ff <= xfm_in;
      end
   end

   assign out_xfm = xfm_ff;

endmodule

### hw/rtl/mppv_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a tag riding along.
// Depends on mppv_pkg for default widths.
module mppv_div #(
   parameter int NUM_W = mppv_pkg::NumW,
   parameter int DEN_W = mppv_pkg::DenW,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   input  logic [TAG_W-1:0] tag,
   output logic [NUM_W-1:0] quo,
   output logic [TAG_W-1:0] tag_out
);
   import mppv_pkg::*;

   logic [NUM_W-1:0] num_ff [NUM_W];
   logic [NUM_W-1:0] quo_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [TAG_W-1:0] tag_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [NUM_W-1:0] num_in, quo_in, quo_set;
      logic [DEN_W-1:0] den_in, rem_in;
      logic [TAG_W-1:0] tag_in;
      logic [DEN_W:0]   trial, diff;
      if (k == 0) begin : g_first
         assign num_in = num;
         assign quo_in = '0;
         assign den_in = den;
         assign rem_in = '0;
         assign tag_in = tag;
      end else begin : g_next
         assign num_in = num_ff[k-1];
         assign quo_in = quo_ff[k-1];
         assign den_in = den_ff[k-1];
         assign rem_in = rem_ff[k-1];
         assign tag_in = tag_ff[k-1];
      end
      assign trial   = {rem_in, num_in[NUM_W-1-k]};
      assign diff    = trial - {1'b0, den_in};
      assign quo_set = quo_in | (NUM_W'(1) << (NUM_W-1-k));

      always_ff @(posedge clock) begin
         num_ff[k] <= num_in;
         den_ff[k] <= den_in;
         if (trial >= {1'b0, den_in}) begin
            rem_ff[k] <= diff[DEN_W-1:0];
            quo_ff[k] <= quo_set;
         end else begin
            rem_ff[k] <= trial[DEN_W-1:0];
            quo_ff[k] <= quo_in;
         end
         if (reset) begin
            tag_ff[k] <= '0;
         end else begin
            tag_ff[k] <= tag_in;
         end
      end
   end

   assign quo     = quo_ff[NUM_W-1];
   assign tag_out = tag_ff[NUM_W-1];

endmodule
